// ===== rtl/ppsch_pkg.sv =====
package ppsch_pkg;

  localparam int TIME_W = 16;
  localparam int PRI_W  = 8;
  localparam int SLOT_W = 4;
  localparam int DONE_W = 5;

  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [DONE_W-1:0] COUNT_MAX = '1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_WAIT,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic              found;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] rem;
  } cand_t;

  typedef struct packed {
    logic              load;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRI_W-1:0]  pri;
  } load_t;

endpackage

// ===== rtl/ppsch_cell.sv =====
module ppsch_cell import ppsch_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  load_t             ld,
  input  logic              dec,
  input  logic [IDX_W-1:0]  dec_idx,
  input  logic [TIME_W-1:0] now,
  input  cand_t             cand_in,
  input  logic [IDX_W-1:0]  idx_in,
  output cand_t             cand_out,
  output logic [IDX_W-1:0]  idx_out
);

  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] burst;
  logic [TIME_W-1:0] rem;
  logic [PRI_W-1:0]  pri;
  logic              hit_load;
  logic              eligible;
  logic              take;
  cand_t             own;

  assign hit_load = ld.load && ({{(32-SLOT_W){1'b0}}, ld.slot} == 32'(INDEX));
  assign eligible = (rem != '0) && (arrival <= now);
  assign take     = eligible && (!cand_in.found || (pri < cand_in.pri));

  always_comb begin
    own.found   = 1'b1;
    own.pri     = pri;
    own.arrival = arrival;
    own.burst   = burst;
    own.rem     = rem;
  end

  always_ff @(posedge clk) begin
    if (hit_load) begin
      arrival <= ld.arrival;
      burst   <= ld.burst;
      pri     <= ld.pri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (hit_load) begin
      rem <= ld.burst;
    end else if (dec && (dec_idx == IDX_W'(INDEX))) begin
      rem <= rem - TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    cand_out <= take ? own : cand_in;
    idx_out  <= take ? IDX_W'(INDEX) : idx_in;
  end

endmodule

// ===== rtl/preemptive_priority_scheduler.sv =====
// Load request: goes IDLE -> PUT; result registered in PUT once the output is free, then IDLE.
// Tick request: goes IDLE -> SCAN -> EXEC -> WAIT -> PUT, the candidate walking the row of slot
//   cells during SCAN; no new request is taken until the result is registered in PUT.
// A new request is taken while the previous result still waits at the output.
// Synchronous reset empties all slots and clears time, completion count and process_count.
module preemptive_priority_scheduler import ppsch_pkg::*; #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [SLOT_W-1:0] slot_index,
  input  logic [TIME_W-1:0] arrival,
  input  logic [TIME_W-1:0] burst,
  input  logic [PRI_W-1:0]  priority_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ran,
  output logic [SLOT_W-1:0] ran_index,
  output logic              finished,
  output logic [TIME_W-1:0] wait_time,
  output logic [TIME_W-1:0] turnaround,
  output logic [TIME_W-1:0] tick_time,
  output logic              all_done,
  input  logic              cfg_wr_en,
  input  logic [DONE_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  cnt;
  logic [TIME_W-1:0] cur_time;
  logic [DONE_W-1:0] done_cnt;
  logic [DONE_W-1:0] pcount;

  logic              r_ran;
  logic [SLOT_W-1:0] r_idx;
  logic              r_fin;
  logic [TIME_W-1:0] r_tat;
  logic [TIME_W-1:0] r_wait;
  logic [TIME_W-1:0] r_burst;
  logic [TIME_W-1:0] r_tick;

  cand_t             chain_c [MAX_PROCESSES+1];
  logic [IDX_W-1:0]  chain_i [MAX_PROCESSES+1];
  cand_t             win;
  logic [IDX_W-1:0]  win_idx;
  logic [31:0]       win_idx_ext;
  load_t             ld;
  logic              accept;
  logic              dec;
  logic              win_fin;
  logic [TIME_W-1:0] fin_time;
  logic              out_free;

  assign accept      = in_valid && !in_stall;
  assign win         = chain_c[MAX_PROCESSES];
  assign win_idx     = chain_i[MAX_PROCESSES];
  assign win_idx_ext = 32'(win_idx);
  assign win_fin     = win.found && (win.rem == TIME_W'(1));
  assign fin_time    = (cur_time < TIME_MAX) ? cur_time + TIME_W'(1) : TIME_MAX;
  assign dec         = (state == ST_EXEC) && win.found;
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    ld.load    = accept && (func == FUNC_LOAD);
    ld.slot    = slot_index;
    ld.arrival = arrival;
    ld.burst   = burst;
    ld.pri     = priority_req;
  end

  assign chain_c[0] = '0;
  assign chain_i[0] = '0;

  for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
    ppsch_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ld       (ld),
      .dec      (dec),
      .dec_idx  (win_idx),
      .now      (cur_time),
      .cand_in  (chain_c[g]),
      .idx_in   (chain_i[g]),
      .cand_out (chain_c[g+1]),
      .idx_out  (chain_i[g+1])
    );
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (func == FUNC_TICK) ? ST_SCAN : ST_PUT;
        end
      end
      ST_SCAN: begin
        if (cnt == IDX_W'(MAX_PROCESSES - 1)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_WAIT;
      ST_WAIT: state_next = ST_PUT;
      ST_PUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cur_time  <= '0;
      done_cnt  <= '0;
      pcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pcount <= cfg_wr_data;
      end
      if (state == ST_SCAN) begin
        cnt <= cnt + IDX_W'(1);
      end else begin
        cnt <= '0;
      end
      if (state == ST_EXEC) begin
        if (cur_time < TIME_MAX) begin
          cur_time <= cur_time + TIME_W'(1);
        end
        if (win_fin && (done_cnt < COUNT_MAX)) begin
          done_cnt <= done_cnt + DONE_W'(1);
        end
      end
      if (state == ST_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        r_ran  <= 1'b0;
        r_idx  <= '0;
        r_fin  <= 1'b0;
        r_tat  <= '0;
        r_wait <= '0;
        r_tick <= cur_time;
      end
      ST_EXEC: begin
        r_ran   <= win.found;
        r_idx   <= win.found ? win_idx_ext[SLOT_W-1:0] : '0;
        r_fin   <= win_fin;
        r_tat   <= win_fin ? fin_time - win.arrival : '0;
        r_burst <= win.burst;
        r_tick  <= cur_time;
      end
      ST_WAIT: begin
        r_wait <= (r_fin && (r_tat >= r_burst)) ? r_tat - r_burst : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUT && out_free) begin
      ran        <= r_ran;
      ran_index  <= r_idx;
      finished   <= r_fin;
      wait_time  <= r_wait;
      turnaround <= r_tat;
      tick_time  <= r_tick;
      all_done   <= (done_cnt >= pcount);
    end
  end

endmodule

// ===== rtl/ppsch_checker.sv =====
module ppsch_checker import ppsch_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              ran,
  input logic [SLOT_W-1:0] ran_index,
  input logic              finished,
  input logic [TIME_W-1:0] wait_time,
  input logic [TIME_W-1:0] turnaround,
  input logic [TIME_W-1:0] tick_time
);

  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> ran)
    else $error("finished request without a run");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ran |-> (ran_index == '0) && !finished)
    else $error("idle result carries a slot");

  a_unfinished_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !finished |-> (wait_time == '0) && (turnaround == '0))
    else $error("unfinished result carries times");

  a_wait_le_tat: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> (wait_time <= turnaround))
    else $error("wait exceeds turnaround");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tick_time) && $stable(turnaround))
    else $error("stalled result changed");

endmodule

bind preemptive_priority_scheduler ppsch_checker u_ppsch_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .ran        (ran),
  .ran_index  (ran_index),
  .finished   (finished),
  .wait_time  (wait_time),
  .turnaround (turnaround),
  .tick_time  (tick_time)
);
